// ===== rtl/core/cgrs_pkg.sv =====
// ----------------------------------------------------------------------------
// cgrs_pkg: shared types and constants of the color ramp sampler.
// Holds the command codes, default sizes and the reset table contents.
// ----------------------------------------------------------------------------
package cgrs_pkg;

    localparam int MaxPoints        = 16;
    localparam int PositionFracBits = 16;

    localparam int PosW   = 17;
    localparam int ColorW = 32;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_FRONT = 2'd1,
        CMD_BACK  = 2'd2,
        CMD_SAMPLE = 2'd3
    } t_cmd;

    localparam logic [ColorW-1:0] ColorBlack = 32'h0000_00FF;
    localparam logic [ColorW-1:0] ColorWhite = 32'hFFFF_FFFF;

endpackage

// ===== rtl/core/cgrs_if.sv =====
// ----------------------------------------------------------------------------
// cgrs_in_if / cgrs_out_if: valid/ready channels of the color ramp sampler.
// One transaction moves one command or one result.
// ----------------------------------------------------------------------------
interface cgrs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [16:0] position;
    logic [31:0] in_color;

    modport source (output valid, command, position, in_color, input ready);
    modport sink   (input valid, command, position, in_color, output ready);
endinterface

interface cgrs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_color;
    logic        status;

    modport source (output valid, out_color, status, input ready);
    modport sink   (input valid, out_color, status, output ready);
endinterface

// ===== rtl/core/cgrs_div.sv =====
// ----------------------------------------------------------------------------
// cgrs_div: serial restoring divider for one color channel.
// Signed numerator over a positive divisor, quotient truncated toward zero,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cgrs_div #(
    parameter int NumW = 27,
    parameter int DenW = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NumW-1:0]  i_num,
    input  logic        [DenW-1:0]  i_den,
    output logic                    o_done,
    output logic signed [NumW-1:0]  o_quot
);
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] r_quo, n_quo;
    logic [DenW:0]   r_rem, n_rem;
    logic [DenW-1:0] r_den;
    logic            r_neg;
    logic [CntW-1:0] r_cnt;
    logic            r_busy, r_done;
    logic [DenW:0]   w_trial;

    // One restoring step on the magnitude.
    always_comb begin
        w_trial = {r_rem[DenW-1:0], r_quo[NumW-1]};
        n_quo   = {r_quo[NumW-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem    = w_trial - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(NumW);
                r_quo  <= i_num[NumW-1] ? NumW'(-i_num) : i_num;
                r_neg  <= i_num[NumW-1];
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? NumW'(-r_quo) : r_quo;
endmodule

// ===== rtl/core/color_gradient_ramp_sampler_top.sv =====
// ----------------------------------------------------------------------------
// color_gradient_ramp_sampler_top: piecewise-linear RGBA color ramp.
//
//  channel  dir  payload                          role
//  s_in     in   command, position, in_color      table edits and samples
//  m_out    out  out_color, status                one result per command
//
// Positions and colors live in one synchronous memory, read one entry per
// cycle. A sample walks up to MAX_POINTS entries, then, unless the segment
// has zero width, runs four channel divisions one after another. An add
// walks the table and shifts the tail one entry at a time. Set front/back
// read the first or last entry and write back its color. Reset writes the
// two default points in ST_INIT0 and ST_INIT1. The output register holds a
// result while the next command is read in; the core stalls only on a full one.
// ----------------------------------------------------------------------------
module color_gradient_ramp_sampler_top #(
    parameter int MAX_POINTS = cgrs_pkg::MaxPoints
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cgrs_in_if.sink     s_in,
    cgrs_out_if.source  m_out
);
    localparam int IdxW  = $clog2(MAX_POINTS);
    localparam int CntW  = $clog2(MAX_POINTS + 1);
    localparam int PosW  = cgrs_pkg::PosW;
    localparam int ColW  = cgrs_pkg::ColorW;
    localparam int EntW  = PosW + ColW;
    localparam int NumW  = 28;
    localparam int DenW  = PosW + 1;

    typedef enum logic [3:0] {
        ST_INIT0, ST_INIT1, ST_IDLE, ST_RD, ST_CHK, ST_SHRD, ST_SHWR,
        ST_INS, ST_SLO, ST_DIV, ST_DWAIT, ST_OUT
    } t_state;

    // Table memory: {position, color}.
    logic [EntW-1:0] r_mem [MAX_POINTS];
    logic [EntW-1:0] r_rdata;
    logic [IdxW-1:0] w_raddr, w_waddr;
    logic            w_we;
    logic [EntW-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    t_state            r_state;
    logic [CntW-1:0]   r_count;
    logic [1:0]        r_cmd;
    logic [PosW-1:0]   r_pos;
    logic [ColW-1:0]   r_col;
    logic [CntW-1:0]   r_it;
    logic [PosW-1:0]   r_epos, r_spos;
    logic [ColW-1:0]   r_ecol, r_scol, r_res;
    logic [1:0]        r_ch;
    logic              r_ovalid;
    logic [ColW-1:0]   r_ocol;
    logic              r_ostat;
    logic [ColW-1:0]   r_pcol;
    logic              r_pstat;
    logic              r_dstart;
    logic signed [NumW-1:0] r_num;
    logic [DenW-1:0]   r_den;
    logic              w_ddone;
    logic signed [NumW-1:0] w_quot;

    logic [PosW-1:0] w_rpos;
    logic [ColW-1:0] w_rcol;
    assign w_rpos = r_rdata[EntW-1:ColW];
    assign w_rcol = r_rdata[ColW-1:0];

    logic [7:0] w_a, w_b;
    assign w_a = 8'(r_scol >> (5'd24 - {r_ch, 3'b000}));
    assign w_b = 8'(r_ecol >> (5'd24 - {r_ch, 3'b000}));

    // Segment start for the current channel: from memory on the first one.
    logic [PosW-1:0] w_s;
    logic [7:0]      w_av;
    assign w_s  = (r_ch == 2'd0) ? w_rpos : r_spos;
    assign w_av = (r_ch == 2'd0) ? 8'(w_rcol >> 24) : w_a;

    // Memory port selection.
    always_comb begin
        w_raddr = r_it[IdxW-1:0];
        w_we    = 1'b0;
        w_waddr = r_it[IdxW-1:0];
        w_wdata = {r_pos, r_col};
        case (r_state)
            ST_INIT0: begin
                w_we = 1'b1; w_waddr = '0; w_wdata = {PosW'(0), cgrs_pkg::ColorBlack};
            end
            ST_INIT1: begin
                w_we = 1'b1; w_waddr = IdxW'(1);
                w_wdata = {PosW'(1) << cgrs_pkg::PositionFracBits, cgrs_pkg::ColorWhite};
            end
            ST_SHRD: begin
                w_raddr = (r_cmd == cgrs_pkg::CMD_ADD) ? IdxW'(r_it - 1'b1)
                                                       : r_it[IdxW-1:0];
            end
            ST_SHWR:  w_we = 1'b1;
            ST_INS:   w_we = 1'b1;
            ST_SLO:   w_raddr = IdxW'(r_it - 1'b1);
            default:  ;
        endcase
        if (r_state == ST_SHWR) w_wdata = r_rdata;
        // Color edits keep the stored position.
        if (r_state == ST_INS && r_cmd != cgrs_pkg::CMD_ADD) w_wdata = {w_rpos, r_col};
    end

    assign s_in.ready = (r_state == ST_IDLE);
    assign m_out.valid = r_ovalid;
    assign m_out.out_color = r_ocol;
    assign m_out.status = r_ostat;

    cgrs_div #(.NumW(NumW), .DenW(DenW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_num), .i_den(r_den), .o_done(w_ddone), .o_quot(w_quot)
    );

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT0;
            r_count  <= CntW'(2);
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            if (m_out.valid && m_out.ready && r_state != ST_OUT) r_ovalid <= 1'b0;
            case (r_state)
                ST_INIT0: r_state <= ST_INIT1;
                ST_INIT1: r_state <= ST_IDLE;
                ST_IDLE: begin
                    if (s_in.valid && s_in.ready) begin
                        r_cmd <= s_in.command;
                        r_pos <= s_in.position;
                        r_col <= s_in.in_color;
                        r_res <= '0;
                        case (cgrs_pkg::t_cmd'(s_in.command))
                            cgrs_pkg::CMD_ADD: begin
                                if (r_count >= CntW'(MAX_POINTS)) begin
                                    r_pcol <= '0; r_pstat <= 1'b1; r_state <= ST_OUT;
                                end else begin
                                    r_it <= '0; r_state <= ST_RD;
                                end
                            end
                            cgrs_pkg::CMD_FRONT: begin
                                r_it <= '0; r_state <= ST_SHRD;
                            end
                            cgrs_pkg::CMD_BACK: begin
                                r_it <= r_count - 1'b1; r_state <= ST_SHRD;
                            end
                            default: begin
                                r_it <= CntW'(1); r_state <= ST_RD;
                            end
                        endcase
                    end
                end
                ST_RD: r_state <= ST_CHK;
                ST_CHK: begin
                    if (r_cmd == cgrs_pkg::CMD_ADD) begin
                        if (r_it < r_count && w_rpos <= r_pos) begin
                            r_it <= r_it + 1'b1; r_state <= ST_RD;
                        end else begin
                            // Shift position r_it marks the insert slot.
                            r_epos <= PosW'(r_it);
                            r_it   <= r_count;
                            r_state <= (r_count == r_it) ? ST_INS : ST_SHRD;
                        end
                    end else if (w_rpos < r_pos && r_it + 1'b1 != r_count) begin
                        r_it <= r_it + 1'b1; r_state <= ST_RD;
                    end else begin
                        r_epos <= w_rpos; r_ecol <= w_rcol; r_state <= ST_SLO;
                    end
                end
                ST_SHRD: begin
                    if (r_cmd == cgrs_pkg::CMD_ADD) r_state <= ST_SHWR;
                    else r_state <= ST_INS;
                end
                ST_SHWR: begin
                    r_it <= r_it - 1'b1;
                    r_state <= (r_it - 1'b1 == CntW'(r_epos)) ? ST_INS : ST_SHRD;
                end
                ST_INS: begin
                    if (r_cmd == cgrs_pkg::CMD_ADD) r_count <= r_count + 1'b1;
                    r_pcol <= '0; r_pstat <= 1'b0; r_state <= ST_OUT;
                end
                ST_SLO: begin
                    r_ch <= 2'd0; r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_ch == 2'd0) begin
                        r_spos <= w_rpos; r_scol <= w_rcol;
                    end
                    // A zero-width segment gives the end color.
                    if (r_epos <= w_s) begin
                        r_pcol <= r_ecol; r_pstat <= 1'b0; r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_DWAIT;
                    end
                end
                ST_DWAIT: begin
                    if (w_ddone) begin
                        r_res <= (r_res << 8) |
                            ColW'(w_quot < 0 ? 8'd0 : (w_quot > 255 ? 8'd255 : w_quot[7:0]));
                        if (r_ch == 2'd3) begin
                            r_pcol <= (r_res << 8) |
                                ColW'(w_quot < 0 ? 8'd0 : (w_quot > 255 ? 8'd255 : w_quot[7:0]));
                            r_pstat <= 1'b0; r_state <= ST_OUT;
                        end else begin
                            r_ch <= r_ch + 1'b1; r_state <= ST_DIV;
                        end
                    end
                end
                ST_OUT: begin
                    // Load the output register once it is empty or being drained.
                    if (!r_ovalid || m_out.ready) begin
                        r_ocol   <= r_pcol;
                        r_ostat  <= r_pstat;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // Launch a channel divide unless the segment has zero width.
            r_dstart <= (r_state == ST_DIV) && (r_epos > w_s);
        end
    end

    // Divide operands for the current channel.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV) begin
            r_num <= NumW'($signed({1'b0, w_av}) *
                           ($signed({1'b0, r_epos}) - $signed({1'b0, r_pos})))
                   + NumW'($signed({1'b0, w_b}) *
                           ($signed({1'b0, r_pos}) - $signed({1'b0, w_s})));
            r_den <= DenW'(r_epos) - DenW'(w_s);
        end
    end
endmodule

// ===== rtl/core/cgrs_checker.sv =====
// ----------------------------------------------------------------------------
// cgrs_checker: port-level checks of the color ramp sampler.
// Watches the two channels and is bound to the top level.
// ----------------------------------------------------------------------------
module cgrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_color,
    input logic        status
);
    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_color) && $stable(status))
        else $error("result changed while stalled");

    // A stalled result is not withdrawn.
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A full status carries no color.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && status |-> out_color == 32'd0)
        else $error("full status with color");

    // The input closes in the cycle after each accepted command.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after acceptance");
endmodule

bind color_gradient_ramp_sampler_top cgrs_checker u_cgrs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready),
    .out_color(m_out.out_color), .status(m_out.status)
);

// ===== tb/color_gradient_ramp_sampler_checker.sv =====
// ----------------------------------------------------------------------------
// color_gradient_ramp_sampler_checker: result checker of the color ramp.
// Watches both channels, keeps its own copy of the point table, works out
// the color and status of every accepted command and compares them in order.
// ----------------------------------------------------------------------------
module color_gradient_ramp_sampler_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_command,
    input  logic [16:0] i_position,
    input  logic [31:0] i_in_color,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_color,
    input  logic        i_status,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_samples,
    output int          o_full_adds
);

    typedef struct packed {
        logic [31:0] color;
        logic        status;
    } t_ramp_result;

    logic [16:0]  ramp_pos [cgrs_pkg::MaxPoints];
    logic [31:0]  ramp_col [cgrs_pkg::MaxPoints];
    int           ramp_len;
    t_ramp_result expected_results [$];

    // Linear blend of one segment, saturated per channel.
    function automatic logic [31:0] blend_segment(input longint p, input int lo,
                                                  input int hi);
        longint s, e, span, a, b, v;
        logic [31:0] res;
        s = ramp_pos[lo];
        e = ramp_pos[hi];
        span = e - s;
        res = '0;
        if (span <= 0) return ramp_col[hi];
        for (int k = 0; k < 4; k++) begin
            a = (ramp_col[lo] >> (24 - 8 * k)) & 255;
            b = (ramp_col[hi] >> (24 - 8 * k)) & 255;
            v = (a * (e - p) + b * (p - s)) / span;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            res |= 32'(v) << (24 - 8 * k);
        end
        return res;
    endfunction

    // Apply one command to the table and return its result.
    function automatic t_ramp_result apply_ramp_command(input cgrs_pkg::t_cmd cmd,
                                                        input logic [16:0] pos,
                                                        input logic [31:0] col);
        t_ramp_result r;
        int at, idx;
        r = '0;
        case (cmd)
            cgrs_pkg::CMD_ADD: begin
                if (ramp_len >= cgrs_pkg::MaxPoints) begin
                    r.status = 1'b1;
                end else begin
                    at = 0;
                    while (at < ramp_len && ramp_pos[at] <= pos) at++;
                    for (int i = ramp_len; i > at; i--) begin
                        ramp_pos[i] = ramp_pos[i-1];
                        ramp_col[i] = ramp_col[i-1];
                    end
                    ramp_pos[at] = pos;
                    ramp_col[at] = col;
                    ramp_len++;
                end
            end
            cgrs_pkg::CMD_FRONT: ramp_col[0] = col;
            cgrs_pkg::CMD_BACK:  ramp_col[ramp_len-1] = col;
            default: begin
                idx = 1;
                while (ramp_pos[idx] < pos && idx + 1 != ramp_len) idx++;
                r.color = blend_segment(longint'(pos), idx - 1, idx);
            end
        endcase
        return r;
    endfunction

    assign o_pending = expected_results.size();

    // Predict on accepted commands and compare accepted results.
    always @(posedge i_clk) begin
        t_ramp_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < cgrs_pkg::MaxPoints; i++) begin
                ramp_pos[i] = '0;
                ramp_col[i] = '0;
            end
            ramp_pos[1] = 17'(1 << cgrs_pkg::PositionFracBits);
            ramp_col[0] = cgrs_pkg::ColorBlack;
            ramp_col[1] = cgrs_pkg::ColorWhite;
            ramp_len = 2;
            expected_results.delete();
            o_fail_count <= 0;
            o_samples <= 0;
            o_full_adds <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("Unexpected result transaction: color %h status %b",
                                 i_out_color, i_status);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.color !== i_out_color || exp_r.status !== i_status) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("Mismatch: expected color %h status %b, got %h %b",
                                     exp_r.color, exp_r.status, i_out_color, i_status);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                exp_r = apply_ramp_command(cgrs_pkg::t_cmd'(i_command), i_position,
                                           i_in_color);
                expected_results.insert(expected_results.size(), exp_r);
                if (cgrs_pkg::t_cmd'(i_command) == cgrs_pkg::CMD_SAMPLE)
                    o_samples <= o_samples + 1;
                if (exp_r.status) o_full_adds <= o_full_adds + 1;
            end
        end
    end

endmodule

// ===== tb/color_gradient_ramp_sampler_top_tb.sv =====
// ----------------------------------------------------------------------------
// color_gradient_ramp_sampler_top_tb: stimulus and verdict of the color ramp.
// Builds ramps of random points with random edits and samples, fills the
// table once while the receiver holds off, and lets the checker compare
// every result while both sides stall at random.
// ----------------------------------------------------------------------------
module color_gradient_ramp_sampler_top_tb;

    localparam int RandomItems = 1430;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, samples, full_adds;
    int   sent;
    bit   hold_off;

    cgrs_in_if  in_ch ();
    cgrs_out_if out_ch ();

    color_gradient_ramp_sampler_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (in_ch),
        .m_out  (out_ch)
    );

    color_gradient_ramp_sampler_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_command   (in_ch.command),
        .i_position  (in_ch.position),
        .i_in_color  (in_ch.in_color),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_color (out_ch.out_color),
        .i_status    (out_ch.status),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_samples   (samples),
        .o_full_adds (full_adds)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [16:0] rand_position();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF - 17'($urandom_range(0, 3));
            3: return 17'($urandom_range(65530, 65542));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Offer one command and wait for its transaction.
    task automatic send_command(input cgrs_pkg::t_cmd cmd, input logic [16:0] pos,
                                input logic [31:0] col);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.command  <= cmd;
        in_ch.position <= pos;
        in_ch.in_color <= col;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        bit held;
        held = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off && !held) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                held = 1'b1;
            end
            out_ch.ready <= (gap_len() == 0);
        end
    end

    initial begin
        #4000000;
        $display("color_gradient_ramp_sampler_top_tb: FAIL");
        $finish;
    end

    initial begin
        int kind;
        in_ch.valid = 1'b0;
        in_ch.command = cgrs_pkg::CMD_ADD;
        in_ch.position = '0;
        in_ch.in_color = '0;
        hold_off = 1'b0;
        sent = 0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default ramp, extremes, equal positions, full table.
        send_command(cgrs_pkg::CMD_SAMPLE, 17'd0, '0);
        send_command(cgrs_pkg::CMD_SAMPLE, 17'd32768, '0);
        send_command(cgrs_pkg::CMD_SAMPLE, 17'd65536, '0);
        send_command(cgrs_pkg::CMD_SAMPLE, 17'h1FFFF, '0);
        send_command(cgrs_pkg::CMD_FRONT, 17'h1FFFF, 32'hFF00_FF00);
        send_command(cgrs_pkg::CMD_BACK, 17'd0, 32'h00FF_00FF);
        send_command(cgrs_pkg::CMD_SAMPLE, 17'd16384, '0);
        send_command(cgrs_pkg::CMD_ADD, 17'd0, 32'h1234_5678);
        send_command(cgrs_pkg::CMD_SAMPLE, 17'd0, '0);
        send_command(cgrs_pkg::CMD_ADD, 17'd32768, 32'hFFFF_FFFF);
        send_command(cgrs_pkg::CMD_ADD, 17'd32768, 32'h0000_0000);
        send_command(cgrs_pkg::CMD_SAMPLE, 17'd32768, '0);
        send_command(cgrs_pkg::CMD_ADD, 17'h1FFFF, 32'hA5A5_A5A5);
        send_command(cgrs_pkg::CMD_SAMPLE, 17'h1FFFE, '0);
        hold_off = 1'b1;
        for (int i = 0; i < 11; i++)
            send_command(cgrs_pkg::CMD_ADD, 17'($urandom_range(0, 65536)), $urandom);
        send_command(cgrs_pkg::CMD_BACK, 17'd5, 32'h5A5A_5A5A);
        send_command(cgrs_pkg::CMD_SAMPLE, 17'h1FFFF, '0);

        // Random: mostly samples on a full table, with edits.
        for (int i = 0; i < RandomItems; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 2)
                send_command(cgrs_pkg::CMD_ADD, rand_position(), $urandom);
            else if (kind < 3)
                send_command(cgrs_pkg::CMD_FRONT, rand_position(), $urandom);
            else if (kind < 4)
                send_command(cgrs_pkg::CMD_BACK, rand_position(), $urandom);
            else
                send_command(cgrs_pkg::CMD_SAMPLE, rand_position(), $urandom);
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d commands: %0d samples checked, %0d adds on a full table.",
                 sent, samples, full_adds);
        if (fail_count == 0)
            $display("color_gradient_ramp_sampler_top_tb: PASS");
        else
            $display("color_gradient_ramp_sampler_top_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cgrs_pkg.sv
rtl/core/cgrs_if.sv
rtl/core/cgrs_div.sv
rtl/core/color_gradient_ramp_sampler_top.sv
rtl/core/cgrs_checker.sv
tb/color_gradient_ramp_sampler_checker.sv
tb/color_gradient_ramp_sampler_top_tb.sv
